>>> design/frwl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frwl_pkg
// Shared types and constants of the fair reader/writer lock manager.
// ----------------------------------------------------------------------------
package frwl_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF     = 4;

  localparam int          RDR_W       = 5;
  localparam logic [4:0]  READERS_MAX = 5'd31;

  localparam logic ROLE_WRITER = 1'b0;
  localparam logic ROLE_READER = 1'b1;

  localparam logic KIND_ACQUIRE = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    EV_GRANTED  = 3'd0,
    EV_QUEUED   = 3'd1,
    EV_RELEASED = 3'd2,
    EV_WOKEN    = 3'd3,
    EV_FULL     = 3'd4,
    EV_RELERR   = 3'd5
  } frwl_event_t;

endpackage
`default_nettype wire

>>> design/frwl_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frwl_in_if / frwl_out_if
// Valid/ready channels for lock requests and lock results.
// ----------------------------------------------------------------------------
interface frwl_in_if #(
  parameter int ID_BITS = frwl_pkg::ID_BITS_DEF
);
  logic               valid;
  logic               ready;
  logic               kind;
  logic               role;
  logic [ID_BITS-1:0] requester_id;

  modport source (output valid, kind, role, requester_id, input ready);
  modport sink   (input valid, kind, role, requester_id, output ready);
endinterface

interface frwl_out_if #(
  parameter int ID_BITS = frwl_pkg::ID_BITS_DEF
);
  logic               valid;
  logic               ready;
  logic [2:0]         event_res;
  logic [ID_BITS-1:0] grant_id;
  logic               grant_role;
  logic               last;

  modport source (output valid, event_res, grant_id, grant_role, last, input ready);
  modport sink   (input valid, event_res, grant_id, grant_role, last, output ready);
endinterface
`default_nettype wire

>>> design/frwl_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frwl_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module frwl_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> design/fair_reader_writer_lock_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fair_reader_writer_lock_top
// FIFO-fair reader/writer lock manager with a RAM-based wait queue.
// ----------------------------------------------------------------------------
// An acquire, or a release that finds the wait queue empty, is taken and gives
// one result; a new request is taken every cycle while results drain. A release
// that finds waiters reads the queue head from the wait RAM, a registered read,
// and then wakes one entry per cycle while the result channel does not stall;
// the registered read of each queue head sets that pace. Results of one request
// carry last on the final one. No requests are taken while a wake sequence
// runs, and a stalled result channel holds off both new requests and the wake
// sequence.
// ----------------------------------------------------------------------------
module fair_reader_writer_lock_top #(
  parameter int QUEUE_DEPTH = frwl_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = frwl_pkg::ID_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  frwl_in_if.sink     in_ch,
  frwl_out_if.source  out_ch
);

  import frwl_pkg::*;

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int ENT_W  = ID_BITS + 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CHK  = 3'b010,
    ST_LAST = 3'b100
  } state_t;

  state_t              st_r, st_nxt;
  logic [RDR_W-1:0]    rdr_r, rdr_nxt;
  logic                wr_hold_r, wr_hold_nxt;
  logic [PTR_W-1:0]    head_r, head_nxt;
  logic [PTR_W-1:0]    tail_r, tail_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;

  logic                out_vld_r, out_vld_nxt;
  frwl_event_t         out_ev_r, out_ev_nxt;
  logic [ID_BITS-1:0]  out_id_r, out_id_nxt;
  logic                out_role_r, out_role_nxt;
  logic                out_last_r, out_last_nxt;

  frwl_event_t         pend_ev_r, pend_ev_nxt;
  logic [ID_BITS-1:0]  pend_id_r, pend_id_nxt;
  logic                pend_role_r, pend_role_nxt;

  logic                ram_wr_en;
  logic                ram_rd_en;
  logic [ENT_W-1:0]    ram_wr_data;
  logic [ENT_W-1:0]    ram_rd_data;

  logic                out_free;
  logic                in_acc;
  logic                ent_role;
  logic [ID_BITS-1:0]  ent_id;

  function automatic logic compatible(logic wr_hold, logic [RDR_W-1:0] rdr, logic role);
    logic ok;
    if (wr_hold) begin
      ok = 1'b0;
    end else if (role == ROLE_READER) begin
      ok = (rdr != READERS_MAX);
    end else begin
      ok = (rdr == '0);
    end
    return ok;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] q;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      q = '0;
    end else begin
      q = p + PTR_W'(1);
    end
    return q;
  endfunction

  assign out_free     = !out_vld_r || out_ch.ready;
  assign in_ch.ready  = (st_r == ST_IDLE) && out_free;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign ent_role     = ram_rd_data[ID_BITS];
  assign ent_id       = ram_rd_data[ID_BITS-1:0];
  assign ram_wr_data  = {in_ch.role, in_ch.requester_id};

  assign out_ch.valid      = out_vld_r;
  assign out_ch.event_res  = out_ev_r;
  assign out_ch.grant_id   = out_id_r;
  assign out_ch.grant_role = out_role_r;
  assign out_ch.last       = out_last_r;

  always_comb begin
    st_nxt        = st_r;
    rdr_nxt       = rdr_r;
    wr_hold_nxt   = wr_hold_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    fill_nxt      = fill_r;
    out_vld_nxt   = out_vld_r && !out_ch.ready;
    out_ev_nxt    = out_ev_r;
    out_id_nxt    = out_id_r;
    out_role_nxt  = out_role_r;
    out_last_nxt  = out_last_r;
    pend_ev_nxt   = pend_ev_r;
    pend_id_nxt   = pend_id_r;
    pend_role_nxt = pend_role_r;
    ram_wr_en     = 1'b0;
    ram_rd_en     = 1'b0;

    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          out_id_nxt   = in_ch.requester_id;
          out_role_nxt = in_ch.role;
          out_last_nxt = 1'b1;
          out_vld_nxt  = 1'b1;
          if (in_ch.kind == KIND_ACQUIRE) begin
            if (fill_r == '0 && compatible(wr_hold_r, rdr_r, in_ch.role)) begin
              out_ev_nxt = EV_GRANTED;
              if (in_ch.role == ROLE_READER) begin
                rdr_nxt = rdr_r + RDR_W'(1);
              end else begin
                wr_hold_nxt = 1'b1;
              end
            end else if (fill_r == FILL_W'(QUEUE_DEPTH)) begin
              out_ev_nxt = EV_FULL;
            end else begin
              out_ev_nxt = EV_QUEUED;
              ram_wr_en  = 1'b1;
              tail_nxt   = ptr_inc(tail_r);
              fill_nxt   = fill_r + FILL_W'(1);
            end
          end else begin
            if ((in_ch.role == ROLE_READER) ? (rdr_r == '0) : !wr_hold_r) begin
              out_ev_nxt = EV_RELERR;
            end else begin
              if (in_ch.role == ROLE_READER) begin
                rdr_nxt = rdr_r - RDR_W'(1);
              end else begin
                wr_hold_nxt = 1'b0;
              end
              if (fill_r == '0) begin
                out_ev_nxt = EV_RELEASED;
              end else begin
                // hold the release result until the queue head is checked
                out_vld_nxt   = out_vld_r && !out_ch.ready;
                out_id_nxt    = out_id_r;
                out_role_nxt  = out_role_r;
                out_last_nxt  = out_last_r;
                pend_ev_nxt   = EV_RELEASED;
                pend_id_nxt   = in_ch.requester_id;
                pend_role_nxt = in_ch.role;
                ram_rd_en     = 1'b1;
                st_nxt        = ST_CHK;
              end
            end
          end
        end
      end
      ST_CHK: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_ev_nxt   = pend_ev_r;
          out_id_nxt   = pend_id_r;
          out_role_nxt = pend_role_r;
          if (!compatible(wr_hold_r, rdr_r, ent_role)) begin
            out_last_nxt = 1'b1;
            st_nxt       = ST_IDLE;
          end else begin
            out_last_nxt  = 1'b0;
            pend_ev_nxt   = EV_WOKEN;
            pend_id_nxt   = ent_id;
            pend_role_nxt = ent_role;
            if (ent_role == ROLE_READER) begin
              rdr_nxt = rdr_r + RDR_W'(1);
            end else begin
              wr_hold_nxt = 1'b1;
            end
            head_nxt = ptr_inc(head_r);
            fill_nxt = fill_r - FILL_W'(1);
            if (fill_r == FILL_W'(1)) begin
              st_nxt = ST_LAST;
            end else begin
              ram_rd_en = 1'b1;
            end
          end
        end
      end
      ST_LAST: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_ev_nxt   = pend_ev_r;
          out_id_nxt   = pend_id_r;
          out_role_nxt = pend_role_r;
          out_last_nxt = 1'b1;
          st_nxt       = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      rdr_r     <= '0;
      wr_hold_r <= 1'b0;
      head_r    <= '0;
      tail_r    <= '0;
      fill_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      rdr_r     <= rdr_nxt;
      wr_hold_r <= wr_hold_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      fill_r    <= fill_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_ev_r    <= out_ev_nxt;
    out_id_r    <= out_id_nxt;
    out_role_r  <= out_role_nxt;
    out_last_r  <= out_last_nxt;
    pend_ev_r   <= pend_ev_nxt;
    pend_id_r   <= pend_id_nxt;
    pend_role_r <= pend_role_nxt;
  end

  frwl_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_wait_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (tail_r),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (head_nxt),
    .rd_data (ram_rd_data)
  );

endmodule
`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the fair reader/writer lock manager. Lock requests and releases
// are sent through the request channel, first a short directed sequence and
// then random scenarios: balanced traffic, reader floods that saturate the
// reader count, queue fills up to overflow, drains and plain noise. A
// scoreboard tracks holders and the wait queue of its own and checks every
// result transaction, field by field and in order. Both channels idle at
// random in the first two phases, and the result side holds off for a long stretch
// once so that backpressure reaches the request side.
// ----------------------------------------------------------------------------
module tb_top;
  import frwl_pkg::*;

  localparam int QDEPTH      = QUEUE_DEPTH_DEF;
  localparam int ID_W        = ID_BITS_DEF;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic            role;
    logic [ID_W-1:0] id;
  } waiter_t;

  typedef struct packed {
    frwl_event_t     ev;
    logic [ID_W-1:0] id;
    logic            role;
    logic            last;
  } lock_result_t;

  class lock_ledger;
    logic [RDR_W-1:0] reader_cnt;
    logic             writer_held;
    waiter_t          waitq[$];
    lock_result_t     due_results[$];
    int               errors;

    function new();
      reader_cnt  = '0;
      writer_held = 1'b0;
      errors      = 0;
    endfunction

    function bit may_take(logic role);
      if (writer_held) return 1'b0;
      if (role == ROLE_READER) return reader_cnt < READERS_MAX;
      return reader_cnt == 0;
    endfunction

    function void take_lock(logic role);
      if (role == ROLE_READER) reader_cnt++;
      else writer_held = 1'b1;
    endfunction

    function void push_due(frwl_event_t ev, logic [ID_W-1:0] id, logic role);
      due_results.push_back('{ev: ev, id: id, role: role, last: 1'b0});
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void note_request(logic kind, logic role, logic [ID_W-1:0] id);
      waiter_t w;
      if (kind == KIND_ACQUIRE) begin
        if (waitq.size() == 0 && may_take(role)) begin
          take_lock(role);
          push_due(EV_GRANTED, id, role);
        end else if (waitq.size() >= QDEPTH) begin
          push_due(EV_FULL, id, role);
        end else begin
          waitq.push_back('{role: role, id: id});
          push_due(EV_QUEUED, id, role);
        end
      end else if (role == ROLE_READER ? reader_cnt == 0 : !writer_held) begin
        push_due(EV_RELERR, id, role);
      end else begin
        if (role == ROLE_READER) reader_cnt--;
        else writer_held = 1'b0;
        push_due(EV_RELEASED, id, role);
        while (waitq.size() != 0 && may_take(waitq[0].role)) begin
          w = waitq.pop_front();
          take_lock(w.role);
          push_due(EV_WOKEN, w.id, w.role);
        end
      end
      due_results[due_results.size()-1].last = 1'b1;
    endfunction

    function void check_result(logic [2:0] ev, logic [ID_W-1:0] id, logic role, logic last);
      lock_result_t exp;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result ev=%0d id=%0d role=%0d last=%0d",
                   $realtime, ev, id, role, last);
        return;
      end
      exp = due_results.pop_front();
      if (exp.ev !== ev || exp.id !== id || exp.role !== role || exp.last !== last) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display({"%0t: mismatch expected ev=%0d id=%0d role=%0d last=%0d, ",
                    "got ev=%0d id=%0d role=%0d last=%0d"},
                   $realtime, exp.ev, exp.id, exp.role, exp.last, ev, id, role, last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   hold_asked;
  int   hold_done;
  int   hold_left;
  int   stall_cycles;
  int   sent_count;

  lock_ledger ledger = new();

  frwl_in_if  #(.ID_BITS(ID_W)) in_ch();
  frwl_out_if #(.ID_BITS(ID_W)) out_ch();

  fair_reader_writer_lock_top #(
    .QUEUE_DEPTH(QDEPTH),
    .ID_BITS    (ID_W)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        ledger.note_request(in_ch.kind, in_ch.role, in_ch.requester_id);
      if (out_ch.valid && out_ch.ready)
        ledger.check_result(out_ch.event_res, out_ch.grant_id, out_ch.grant_role, out_ch.last);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_asked != hold_done) begin
      out_ch.ready <= 1'b0;
      hold_done    <= hold_asked;
      hold_left    <= HOLD_CYCLES;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  task automatic send_request(logic kind, logic role, logic [ID_W-1:0] id);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= kind;
    in_ch.role         <= role;
    in_ch.requester_id <= id;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_count++;
  endtask

  function automatic logic [ID_W-1:0] any_id();
    return ID_W'($urandom_range(0, (1 << ID_W) - 1));
  endfunction

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  // release whatever is held; with nothing held this becomes a release error
  task automatic release_held();
    logic role;
    if (ledger.writer_held) role = ROLE_WRITER;
    else if (ledger.reader_cnt != 0) role = ROLE_READER;
    else role = logic'($urandom_range(1));
    send_request(KIND_RELEASE, role, any_id());
  endtask

  task automatic drain_lock();
    while (ledger.writer_held || ledger.reader_cnt != 0 || ledger.waitq.size() != 0)
      release_held();
  endtask

  task automatic random_step(int acq_pct, int rd_pct);
    if ($urandom_range(99) < acq_pct)
      send_request(KIND_ACQUIRE, ($urandom_range(99) < rd_pct) ? ROLE_READER : ROLE_WRITER,
                   any_id());
    else if ($urandom_range(99) < 85)
      release_held();
    else
      send_request(KIND_RELEASE, logic'($urandom_range(1)), any_id());
  endtask

  // saturate the reader count, then queue readers behind the full count
  task automatic flood_readers();
    drain_lock();
    repeat (int'(READERS_MAX) + $urandom_range(1, 4))
      send_request(KIND_ACQUIRE, ROLE_READER, any_id());
    send_request(KIND_RELEASE, ROLE_READER, any_id());
    repeat ($urandom_range(2, 6)) random_step(30, 70);
  endtask

  // ask for the lock as a writer, then send acquires to fill the wait queue, at times past its depth
  task automatic fill_queue();
    bit readers_only;
    readers_only = bit'($urandom_range(1));
    send_request(KIND_ACQUIRE, ROLE_WRITER, any_id());
    repeat (QDEPTH + $urandom_range(0, 3))
      send_request(KIND_ACQUIRE, readers_only ? ROLE_READER : logic'($urandom_range(1)),
                   any_id());
    repeat ($urandom_range(2, 8)) release_held();
  endtask

  task automatic run_random(int count);
    int target;
    target = sent_count + count;
    fill_queue();
    flood_readers();
    while (sent_count < target) begin
      case ($urandom_range(9))
        0: flood_readers();
        1, 2: fill_queue();
        3: repeat (10)
          send_request(logic'($urandom_range(1)), logic'($urandom_range(1)), any_id());
        default: repeat (20) random_step(55, 50);
      endcase
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.kind         = KIND_ACQUIRE;
    in_ch.role         = ROLE_WRITER;
    in_ch.requester_id = '0;
    out_ch.ready       = 1'b0;
    hold_asked         = 0;
    hold_done          = 0;
    hold_left          = 0;
    stall_cycles       = 0;
    sent_count         = 0;
    tx_idle_pct        = 36;
    rx_idle_pct        = 70;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(KIND_RELEASE, ROLE_WRITER, ID_W'(0));
    send_request(KIND_RELEASE, ROLE_READER, ID_W'(15));
    send_request(KIND_ACQUIRE, ROLE_WRITER, ID_W'(15));
    send_request(KIND_ACQUIRE, ROLE_READER, ID_W'(0));
    send_request(KIND_ACQUIRE, ROLE_WRITER, ID_W'(0));
    send_request(KIND_ACQUIRE, ROLE_READER, ID_W'(10));
    send_request(KIND_RELEASE, ROLE_READER, ID_W'(3));
    send_request(KIND_RELEASE, ROLE_WRITER, ID_W'(15));
    send_request(KIND_ACQUIRE, ROLE_READER, ID_W'(5));
    send_request(KIND_RELEASE, ROLE_READER, ID_W'(0));
    send_request(KIND_RELEASE, ROLE_WRITER, ID_W'(0));
    send_request(KIND_RELEASE, ROLE_READER, ID_W'(10));
    send_request(KIND_RELEASE, ROLE_READER, ID_W'(5));
    send_request(KIND_ACQUIRE, ROLE_READER, ID_W'(6));
    send_request(KIND_ACQUIRE, ROLE_WRITER, ID_W'(9));
    send_request(KIND_RELEASE, ROLE_READER, ID_W'(6));
    send_request(KIND_RELEASE, ROLE_WRITER, ID_W'(9));
    run_random(115);
    wait_drained();

    tx_idle_pct = 70;
    rx_idle_pct = 36;
    run_random(140);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_asked++;
    run_random(140);
    wait_drained();
    repeat (20) @(posedge clk);

    if (ledger.errors == 0 && ledger.pending() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end
endmodule
